// ===== sv/blzd_pkg.sv =====
package blzd_pkg;

   localparam int unsigned HistDepth = 65536;
   localparam int unsigned HistAw = (HistDepth > 1) ? $clog2(HistDepth) : 1;

   localparam logic [16:0] LenMax = 17'h1FFFF;
   localparam logic [16:0] LenRun = 17'h00017;

   typedef enum logic [1:0] {
      ST_DATA = 2'd0,
      ST_NEED = 2'd1,
      ST_DONE = 2'd2,
      ST_ERR  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      PH_FLAG, PH_LEN_A, PH_LEN_C, PH_LEN_D, PH_OFF_A, PH_OFF_B,
      PH_LIT, PH_B1, PH_B2, PH_B4, PH_EXT, PH_RUN5, PH_OFF5, PH_OFF9, PH_OFFL,
      PH_COPY, PH_DONE, PH_ERR
   } phase_type;

   typedef enum logic [1:0] {
      CTL_IDLE, CTL_STEP, CTL_READ, CTL_EMIT
   } ctl_type;

   typedef enum logic {
      REG_SIZE = 1'b0,
      REG_LOB  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [15:0] unpacked_size;
      logic [4:0]  long_offset_bits;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [HistAw-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic              rd_en;
      logic [HistAw-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== sv/blzd_if.sv =====
interface blzd_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] packed_byte;
   logic       final_packed;
   modport source (output valid, func, packed_byte, final_packed, input ready);
   modport sink (input valid, func, packed_byte, final_packed, output ready);
endinterface

interface blzd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [7:0]  out_byte;
   logic [15:0] out_position;
   modport source (output valid, status, out_byte, out_position, input ready);
   modport sink (input valid, status, out_byte, out_position, output ready);
endinterface

// ===== sv/blzd_history.sv =====
module blzd_history
   import blzd_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [HistDepth];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/blzd_decoder.sv =====
module blzd_decoder
   import blzd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   blzd_req_if.sink    req,
   blzd_rsp_if.source  rsp,
   output mem_req_type mem_req,
   input  logic [7:0]  rd_data
);

   ctl_type     ctl_ff, ctl_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  buf_ff, buf_in;
   logic [7:0]  mask_ff, mask_in;
   logic        ended_ff, ended_in;
   logic [16:0] acc_ff, acc_in;
   logic [4:0]  left_ff, left_in;
   logic [16:0] len_ff, len_in;
   logic [16:0] off_ff, off_in;
   logic [16:0] count_ff, count_in;
   status_type  pend_st_ff, pend_st_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic [15:0] pend_pos_ff, pend_pos_in;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_st_ff, rsp_st_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [15:0] rsp_pos_ff, rsp_pos_in;

   logic        is_field;
   logic        bit_avail;
   logic        bit_val;
   logic [17:0] ext_sum;
   logic [16:0] src;
   logic [16:0] new_off;
   logic [16:0] lit_len;
   logic [4:0]  lob;
   logic        set_off;

   assign is_field  = (phase_ff >= PH_LIT) && (phase_ff <= PH_OFFL);
   assign bit_avail = (mask_ff != 8'd0);
   assign bit_val   = |(buf_ff & mask_ff);
   assign ext_sum   = {1'b0, len_ff} + {1'b0, acc_ff};
   assign src       = count_ff - off_ff;
   assign lob       = (cfg.long_offset_bits > 5'd16) ? 5'd16 : cfg.long_offset_bits;
   assign lit_len   = (len_ff != 17'd0) ? len_ff - 17'd1 : len_ff;

   assign req.ready    = (ctl_ff == CTL_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_st_ff;
   assign rsp.out_byte = rsp_byte_ff;
   assign rsp.out_position = rsp_pos_ff;

   always_comb begin
      ctl_in       = ctl_ff;
      phase_in     = phase_ff;
      buf_in       = buf_ff;
      mask_in      = mask_ff;
      ended_in     = ended_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      len_in       = len_ff;
      off_in       = off_ff;
      count_in     = count_ff;
      pend_st_in   = pend_st_ff;
      pend_byte_in = pend_byte_ff;
      pend_pos_in  = pend_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      mem_req      = '0;
      new_off      = 17'd0;
      set_off      = 1'b0;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req.valid) begin
               if (req.func) begin
                  ctl_in = CTL_STEP;
               end else if (!bit_avail && !ended_ff) begin
                  buf_in   = req.packed_byte;
                  mask_in  = 8'h80;
                  ended_in = req.final_packed;
               end
            end
         end
         CTL_STEP: begin
            priority if (phase_ff == PH_DONE) begin
               pend_st_in = ST_DONE; pend_byte_in = '0; pend_pos_in = '0;
               ctl_in = CTL_EMIT;
            end else if (phase_ff == PH_ERR) begin
               pend_st_in = ST_ERR; pend_byte_in = '0; pend_pos_in = '0;
               ctl_in = CTL_EMIT;
            end else if (phase_ff == PH_COPY) begin
               if (len_ff == 17'd0) begin
                  phase_in = PH_FLAG;
               end else if (count_ff >= 17'(HistDepth) || off_ff > count_ff) begin
                  phase_in = PH_ERR;
               end else begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = src[HistAw-1:0];
                  ctl_in = CTL_READ;
               end
            end else if (phase_ff == PH_FLAG && count_ff >= {1'b0, cfg.unpacked_size}) begin
               phase_in = PH_DONE;
            end else if (is_field && left_ff == 5'd0) begin
               unique case (phase_ff)
                  PH_LIT: begin
                     if (count_ff >= 17'(HistDepth)) begin
                        phase_in = PH_ERR;
                     end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = count_ff[HistAw-1:0];
                        mem_req.wr_data = acc_ff[7:0];
                        count_in = count_ff + 17'd1;
                        len_in   = lit_len;
                        if (lit_len == 17'd0) begin
                           phase_in = PH_FLAG;
                        end else begin
                           left_in = 5'd8; acc_in = '0;
                        end
                        pend_st_in   = ST_DATA;
                        pend_byte_in = acc_ff[7:0];
                        pend_pos_in  = count_ff[15:0];
                        ctl_in = CTL_EMIT;
                     end
                  end
                  PH_B1, PH_B2, PH_B4, PH_EXT: begin
                     unique case (phase_ff)
                        PH_B1:   len_in = 17'd2 + acc_ff;
                        PH_B2:   len_in = 17'd4 + acc_ff;
                        PH_B4:   len_in = 17'd8 + acc_ff;
                        default: len_in = ext_sum[17] ? LenMax : ext_sum[16:0];
                     endcase
                     if (phase_ff == PH_EXT && acc_ff == 17'h000FF) begin
                        left_in = 5'd8; acc_in = '0;
                     end else if (len_in == LenRun) begin
                        phase_in = PH_RUN5; left_in = 5'd5; acc_in = '0;
                     end else begin
                        phase_in = PH_OFF_A;
                     end
                  end
                  PH_RUN5: begin
                     len_in = 17'd14 + acc_ff;
                     phase_in = PH_LIT; left_in = 5'd8; acc_in = '0;
                  end
                  PH_OFF5: begin set_off = 1'b1; new_off = 17'd1 + acc_ff; end
                  PH_OFF9: begin set_off = 1'b1; new_off = 17'h21 + acc_ff; end
                  default: begin set_off = 1'b1; new_off = 17'h221 + acc_ff; end
               endcase
               if (set_off) begin
                  off_in   = new_off;
                  phase_in = (new_off > count_ff) ? PH_ERR : PH_COPY;
               end
            end else if (!bit_avail && !ended_ff) begin
               pend_st_in = ST_NEED; pend_byte_in = '0; pend_pos_in = '0;
               ctl_in = CTL_EMIT;
            end else begin
               // past the final byte every bit reads as zero
               logic b;
               b = bit_avail && bit_val;
               if (bit_avail) begin
                  mask_in = mask_ff >> 1;
               end
               if (is_field) begin
                  acc_in  = {acc_ff[15:0], b};
                  left_in = left_ff - 5'd1;
               end else begin
                  unique case (phase_ff)
                     PH_FLAG: begin
                        if (b) phase_in = PH_LEN_A;
                        else begin
                           len_in = 17'd1; phase_in = PH_LIT; left_in = 5'd8; acc_in = '0;
                        end
                     end
                     PH_LEN_A: begin
                        if (b) begin phase_in = PH_B1; left_in = 5'd1; acc_in = '0; end
                        else phase_in = PH_LEN_C;
                     end
                     PH_LEN_C: begin
                        if (b) begin phase_in = PH_B2; left_in = 5'd2; acc_in = '0; end
                        else phase_in = PH_LEN_D;
                     end
                     PH_LEN_D: begin
                        if (b) begin phase_in = PH_B4; left_in = 5'd4; acc_in = '0; end
                        else begin
                           len_in = LenRun; phase_in = PH_EXT; left_in = 5'd8; acc_in = '0;
                        end
                     end
                     PH_OFF_A: begin
                        if (b) begin phase_in = PH_OFFL; left_in = lob; acc_in = '0; end
                        else phase_in = PH_OFF_B;
                     end
                     default: begin
                        left_in = b ? 5'd5 : 5'd9;
                        phase_in = b ? PH_OFF5 : PH_OFF9;
                        acc_in = '0;
                     end
                  endcase
               end
            end
         end
         CTL_READ: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = count_ff[HistAw-1:0];
            mem_req.wr_data = rd_data;
            count_in = count_ff + 17'd1;
            len_in   = len_ff - 17'd1;
            pend_st_in   = ST_DATA;
            pend_byte_in = rd_data;
            pend_pos_in  = count_ff[15:0];
            ctl_in = CTL_EMIT;
         end
         CTL_EMIT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = pend_st_ff;
               rsp_byte_in  = pend_byte_ff;
               rsp_pos_in   = pend_pos_ff;
               ctl_in = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         phase_ff     <= PH_FLAG;
         buf_ff       <= '0;
         mask_ff      <= '0;
         ended_ff     <= 1'b0;
         acc_ff       <= '0;
         left_ff      <= '0;
         len_ff       <= '0;
         off_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         buf_ff       <= buf_in;
         mask_ff      <= mask_in;
         ended_ff     <= ended_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         len_ff       <= len_in;
         off_ff       <= off_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_st_ff   <= pend_st_in;
      pend_byte_ff <= pend_byte_in;
      pend_pos_ff  <= pend_pos_in;
      rsp_st_ff    <= rsp_st_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

endmodule

// ===== sv/backward_lz_bitstream_depacker.sv =====
// Backward LZ depacker. Supply items (func 0) load one packed byte, if the
// bit buffer is empty and no final byte was seen, and give no result. A pull
// item (func 1) walks the token decoder one bit or one field step per cycle
// until it has a byte, a request for more input, or an end/error status. A
// literal byte is written to the history and emitted; a match byte needs a
// registered read of the 64 KiB history RAM followed by a write back. The
// result waits in an output register, so the next supply item is taken while
// it is still pending. Write the two registers over the APB port only while
// the block is idle.
module backward_lz_bitstream_depacker
   import blzd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   blzd_req_if.sink    req,
   blzd_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [15:0] size_ff;
   logic [4:0]  lob_ff;
   cfg_type     cfg;
   mem_req_type mem_req;
   logic [7:0]  rd_data;
   reg_index_type reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = reg_index_type'(paddr[2]);
   assign cfg     = '{unpacked_size: size_ff, long_offset_bits: lob_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         lob_ff  <= '0;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_SIZE: size_ff <= pwdata[15:0];
            REG_LOB:  lob_ff  <= pwdata[4:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_SIZE: prdata = {16'd0, size_ff};
         REG_LOB:  prdata = {27'd0, lob_ff};
         default:  prdata = '0;
      endcase
   end

   blzd_decoder u_decoder (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req),
      .rsp     (rsp),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   blzd_history u_history (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
